FILE: rtl/core/gbr_pkg.sv
// ----------------------------------------------------------------------------
// gbr_pkg
// shared widths, register indexes, reset values and stream kind codes of the
// glyph row renderer
// ----------------------------------------------------------------------------
package gbr_pkg;

    localparam int BYTE_W    = 8;
    localparam int MASK_W    = 32;
    localparam int PIXEL_W   = 32;
    localparam int POS_W     = 12;
    localparam int COORD_W   = 13;
    localparam int CODE_W    = 8;
    localparam int LOAD_AW   = 12;
    localparam int PROD_W    = 16;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam int CFG_W_W    = 6;
    localparam int CFG_H_W    = 6;
    localparam int CFG_GB_W   = 8;
    localparam int CFG_RS_W   = 3;
    localparam int NBYTES_W   = 3;
    localparam int BIDX_W     = 2;

    localparam int S_TDATA_W = 120;
    localparam int M_TDATA_W = 128;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_GLYPH_WIDTH  = 2'd0;
    localparam t_cfg_idx CFG_GLYPH_HEIGHT = 2'd1;
    localparam t_cfg_idx CFG_GLYPH_BYTES  = 2'd2;
    localparam t_cfg_idx CFG_ROW_STRIDE   = 2'd3;

    localparam logic KIND_LOAD   = 1'b0;
    localparam logic KIND_RENDER = 1'b1;

    localparam logic [CFG_W_W-1:0]  RST_GLYPH_WIDTH  = 6'd8;
    localparam logic [CFG_H_W-1:0]  RST_GLYPH_HEIGHT = 6'd16;
    localparam logic [CFG_GB_W-1:0] RST_GLYPH_BYTES  = 8'd16;
    localparam logic [CFG_RS_W-1:0] RST_ROW_STRIDE   = 3'd1;

endpackage

FILE: rtl/core/gbr_ram.sv
// ----------------------------------------------------------------------------
// gbr_ram
// generic single write port, single read port ram with registered read data
// ----------------------------------------------------------------------------
module gbr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

FILE: rtl/core/gbr_mirror.sv
// ----------------------------------------------------------------------------
// gbr_mirror
// shift unit: turns an lsb-first glyph row word into the mirrored
// display mask, bits at and above the width cleared
// ----------------------------------------------------------------------------
module gbr_mirror
    import gbr_pkg::*;
(
    input  logic [MASK_W-1:0]  i_word,
    input  logic [CFG_W_W-1:0] i_width,
    output logic [MASK_W-1:0]  o_mask
);

    logic [MASK_W-1:0]   w_rev;
    logic [CFG_W_W-1:0]  w_shift;
    logic [2*MASK_W-1:0] w_wide;

    always_comb begin
        for (int j = 0; j < MASK_W; j++) begin
            w_rev[j] = i_word[MASK_W-1-j];
        end
    end

    // mask bit k takes word bit width-1-k
    assign w_shift = CFG_W_W'(MASK_W) - i_width;
    assign w_wide  = {{MASK_W{1'b0}}, w_rev} >> w_shift;
    assign o_mask  = w_wide[MASK_W-1:0];

endmodule

FILE: rtl/core/bitmap_glyph_row_renderer_core.sv
// ----------------------------------------------------------------------------
// bitmap_glyph_row_renderer_core
// bitmap font character generator: load beats fill the font store, render
// beats emit one mirrored pixel mask per glyph row, last row on tlast
// ----------------------------------------------------------------------------
//  channel  | dir | handshake              | payload
//  s_axis   | in  | s_axis_tvalid/tready   | tuser kind, tdata load and render fields
//  m_axis   | out | m_axis_tvalid/tready   | tdata row fields, tlast last row
//  cfg      | in  | i_cfg_we               | i_cfg_idx, i_cfg_data
//
//  a load beat writes the font store as it is accepted and the block stays idle
//  a render beat runs a multiply step, then per row one font store read and
//  capture per byte over the single read port, then an output step
//  m_axis_tready low holds the current row; no new beat is taken until the
//  last row has gone
//  reset is synchronous; the font store is not cleared and needs no pass
// ----------------------------------------------------------------------------
module bitmap_glyph_row_renderer_core
    import gbr_pkg::*;
#(
    parameter int FONT_BYTES       = 4096,
    parameter int MAX_GLYPH_WIDTH  = 32,
    parameter int MAX_GLYPH_HEIGHT = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // font_addr, font_byte, char_code, pos_x, pos_y, fg_pixel, bg_pixel
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,
    // kind
    input  logic                  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // row_y, row_x_left, row_mask, row_fg, row_bg
    output logic [M_TDATA_W-1:0]  m_axis_tdata,
    output logic                  m_axis_tlast
);

    // font store depth must be a power of two, the block does not check it; addresses wrap
    localparam int AW  = $clog2(FONT_BYTES);
    localparam int RCW = $clog2(MAX_GLYPH_HEIGHT);
    localparam logic [CFG_W_W-1:0] MAX_W = CFG_W_W'(MAX_GLYPH_WIDTH);
    localparam logic [CFG_H_W-1:0] MAX_H = CFG_H_W'(MAX_GLYPH_HEIGHT);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MUL   = 3'd1;
    localparam logic [2:0] S_FETCH = 3'd2;
    localparam logic [2:0] S_CAP   = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    logic [CFG_W_W-1:0]  r_glyph_width;
    logic [CFG_H_W-1:0]  r_glyph_height;
    logic [CFG_GB_W-1:0] r_glyph_bytes;
    logic [CFG_RS_W-1:0] r_row_stride;

    logic [2:0]          r_state, n_state;
    logic [RCW-1:0]      r_row_cnt, n_row_cnt;
    logic [AW-1:0]       r_row_ptr, n_row_ptr;
    logic [BIDX_W-1:0]   r_byte_idx, n_byte_idx;
    logic                w_load_out;

    logic [CODE_W-1:0]   r_char;
    logic [POS_W-1:0]    r_pos_y;
    logic [COORD_W-1:0]  r_x_left;
    logic [PIXEL_W-1:0]  r_fg, r_bg;
    logic [CFG_W_W-1:0]  r_w;
    logic [CFG_H_W-1:0]  r_h;
    logic [NBYTES_W-1:0] r_nbytes;
    logic [MASK_W-1:0]   r_word, w_word_cap;

    logic [COORD_W-1:0]  r_row_y;
    logic [MASK_W-1:0]   r_mask, w_mask;
    logic                r_last;

    logic                w_in_acc;
    logic [CFG_W_W-1:0]  w_w_sat;
    logic [CFG_H_W-1:0]  w_h_sat;
    logic [CFG_W_W:0]    w_w_round;
    logic [PROD_W-1:0]   w_prod;
    logic [AW-1:0]       w_raddr;
    logic [BYTE_W-1:0]   w_rdata;

    logic [LOAD_AW-1:0]  w_font_addr;
    logic [BYTE_W-1:0]   w_font_byte;

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = (r_state == S_OUT);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;

    assign w_font_addr = s_axis_tdata[11:0];
    assign w_font_byte = s_axis_tdata[19:12];

    assign w_w_sat   = (r_glyph_width > MAX_W) ? MAX_W : r_glyph_width;
    assign w_h_sat   = (r_glyph_height > MAX_H) ? MAX_H : r_glyph_height;
    assign w_w_round = {1'b0, w_w_sat} + (CFG_W_W+1)'(BYTE_W - 1);
    assign w_prod    = PROD_W'(r_char) * PROD_W'(r_glyph_bytes);
    assign w_raddr   = r_row_ptr + AW'(r_byte_idx);

    always_comb begin
        w_word_cap = r_word;
        w_word_cap[r_byte_idx*BYTE_W +: BYTE_W] = w_rdata;
    end

    gbr_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (FONT_BYTES)
    ) u_font_store (
        .i_clk   (i_clk),
        .i_we    (w_in_acc && (s_axis_tuser == KIND_LOAD)),
        .i_waddr (AW'(w_font_addr)),
        .i_wdata (w_font_byte),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    gbr_mirror u_mirror (
        .i_word  (w_word_cap),
        .i_width (r_w),
        .o_mask  (w_mask)
    );

    always_comb begin
        n_state    = r_state;
        n_row_cnt  = r_row_cnt;
        n_row_ptr  = r_row_ptr;
        n_byte_idx = r_byte_idx;
        w_load_out = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc && (s_axis_tuser == KIND_RENDER) && (w_h_sat != '0)) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_row_ptr  = AW'(w_prod);
                n_row_cnt  = '0;
                n_byte_idx = '0;
                if (r_nbytes == '0) begin
                    w_load_out = 1'b1;
                    n_state    = S_OUT;
                end else begin
                    n_state = S_FETCH;
                end
            end
            S_FETCH: begin
                n_state = S_CAP;
            end
            S_CAP: begin
                if (({1'b0, r_byte_idx} + NBYTES_W'(1)) == r_nbytes) begin
                    w_load_out = 1'b1;
                    n_state    = S_OUT;
                end else begin
                    n_byte_idx = r_byte_idx + BIDX_W'(1);
                    n_state    = S_FETCH;
                end
            end
            S_OUT: begin
                if (m_axis_tready) begin
                    if (r_last) begin
                        n_row_cnt = '0;
                        n_row_ptr = '0;
                        n_state   = S_IDLE;
                    end else begin
                        n_row_cnt  = r_row_cnt + RCW'(1);
                        n_row_ptr  = r_row_ptr + AW'(r_row_stride);
                        n_byte_idx = '0;
                        if (r_nbytes == '0) begin
                            w_load_out = 1'b1;
                        end else begin
                            n_state = S_FETCH;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_row_cnt      <= '0;
            r_row_ptr      <= '0;
            r_byte_idx     <= '0;
            r_glyph_width  <= RST_GLYPH_WIDTH;
            r_glyph_height <= RST_GLYPH_HEIGHT;
            r_glyph_bytes  <= RST_GLYPH_BYTES;
            r_row_stride   <= RST_ROW_STRIDE;
        end else begin
            r_state    <= n_state;
            r_row_cnt  <= n_row_cnt;
            r_row_ptr  <= n_row_ptr;
            r_byte_idx <= n_byte_idx;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_GLYPH_WIDTH:  r_glyph_width  <= i_cfg_data[CFG_W_W-1:0];
                    CFG_GLYPH_HEIGHT: r_glyph_height <= i_cfg_data[CFG_H_W-1:0];
                    CFG_GLYPH_BYTES:  r_glyph_bytes  <= i_cfg_data[CFG_GB_W-1:0];
                    CFG_ROW_STRIDE:   r_row_stride   <= i_cfg_data[CFG_RS_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_char   <= s_axis_tdata[27:20];
            r_x_left <= {1'b0, s_axis_tdata[39:28]} + COORD_W'(1);
            r_pos_y  <= s_axis_tdata[51:40];
            r_fg     <= s_axis_tdata[83:52];
            r_bg     <= s_axis_tdata[115:84];
            r_w      <= w_w_sat;
            r_h      <= w_h_sat;
            r_nbytes <= NBYTES_W'(w_w_round >> 3);
        end
        if (r_state == S_CAP) begin
            r_word <= w_word_cap;
        end
        if (w_load_out) begin
            r_row_y <= COORD_W'(r_pos_y) + COORD_W'(n_row_cnt);
            r_mask  <= w_mask;
            r_last  <= ((CFG_H_W'(n_row_cnt) + CFG_H_W'(1)) == r_h);
        end
    end

    assign m_axis_tdata = {{(M_TDATA_W - 2*COORD_W - MASK_W - 2*PIXEL_W){1'b0}},
                           r_bg, r_fg, r_mask, r_x_left, r_row_y};
    assign m_axis_tlast = r_last;

`ifndef SYNTH
    a_ready_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !m_axis_tvalid)
        else $error("input ready while a row is pending");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> s_axis_tready)
        else $error("not idle after last row");

    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE && r_state != S_MUL) |-> (CFG_H_W'(r_row_cnt) < r_h))
        else $error("row counter beyond glyph height");

    a_mask_width: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ((r_mask >> r_w) == '0))
        else $error("mask bits set beyond glyph width");

    a_idle_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> (r_row_cnt == '0 && r_row_ptr == '0))
        else $error("row walk not cleared when idle");
`endif

endmodule

FILE: test/tb_bitmap_glyph_row_renderer_core.sv
// ----------------------------------------------------------------------------
// tb_bitmap_glyph_row_renderer_core
// self-checking bench for the glyph row renderer: font bytes are loaded before
// any glyph that reads them is rendered, every accepted render beat is turned
// into expected row beats by a local model of the font store and registers,
// and each row beat leaving the block is compared field by field; both stream
// sides idle in random bursts outside the unstalled tail, register settings sweep the extremes
// ----------------------------------------------------------------------------
module tb_bitmap_glyph_row_renderer_core;
    import gbr_pkg::*;

    localparam int STORE_SIZE   = 4096;
    localparam int MAX_W        = 32;
    localparam int MAX_H        = 32;
    localparam int DRAIN_CYCLES = 300;
    localparam int CYCLE_LIMIT  = 2000000;
    localparam int ITEM_TARGET  = 330;
    localparam int TAIL_RENDERS = 15;
    localparam int TAIL_BEATS   = 75;

    typedef struct packed {
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] x_left;
        logic [MASK_W-1:0]  mask;
        logic [PIXEL_W-1:0] fg;
        logic [PIXEL_W-1:0] bg;
        logic               last;
    } t_glyph_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                  s_axis_tuser = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_axis_tdata;
    logic                  m_axis_tlast;

    logic [BYTE_W-1:0]   glyph_mem [STORE_SIZE];
    bit                  byte_loaded [STORE_SIZE];
    logic [CFG_W_W-1:0]  width_reg;
    logic [CFG_H_W-1:0]  height_reg;
    logic [CFG_GB_W-1:0] bytes_reg;
    logic [CFG_RS_W-1:0] stride_reg;

    t_glyph_row rows_due[$];
    int         mismatches = 0;
    int         beats_sent = 0;
    int         cycles = 0;
    int         ready_hold = 0;
    bit         quiet = 1'b0;

    bitmap_glyph_row_renderer_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic int eff_width();
        return (width_reg > MAX_W) ? MAX_W : int'(width_reg);
    endfunction

    function automatic int eff_height();
        return (height_reg > MAX_H) ? MAX_H : int'(height_reg);
    endfunction

    function automatic logic [LOAD_AW-1:0] glyph_base(input logic [CODE_W-1:0] code);
        logic [PROD_W-1:0] prod;
        prod = PROD_W'(code) * PROD_W'(bytes_reg);
        return prod[LOAD_AW-1:0];
    endfunction

    // fields from the lowest bit up: font_addr, font_byte, char_code, pos_x,
    // pos_y, fg_pixel, bg_pixel, zero fill
    function automatic logic [S_TDATA_W-1:0] pack_beat(
        input logic [LOAD_AW-1:0] addr, input logic [BYTE_W-1:0] value,
        input logic [CODE_W-1:0] code, input logic [POS_W-1:0] px,
        input logic [POS_W-1:0] py, input logic [PIXEL_W-1:0] fg,
        input logic [PIXEL_W-1:0] bg);
        return {4'b0, bg, fg, py, px, code, value, addr};
    endfunction

    task automatic predict_glyph_rows(input logic [S_TDATA_W-1:0] data);
        logic [CODE_W-1:0]  code;
        logic [POS_W-1:0]   px;
        logic [POS_W-1:0]   py;
        logic [LOAD_AW-1:0] ptr;
        logic [LOAD_AW-1:0] addr;
        logic [BYTE_W-1:0]  b;
        t_glyph_row         row;
        int                 w;
        int                 h;
        code = data[27:20];
        px   = data[39:28];
        py   = data[51:40];
        w    = eff_width();
        h    = eff_height();
        ptr  = glyph_base(code);
        for (int r = 0; r < h; r++) begin
            row.mask = '0;
            for (int col = 0; col < w; col++) begin
                addr = ptr + LOAD_AW'(col / 8);
                b = glyph_mem[addr];
                if (b[col % 8])
                    row.mask[w-1-col] = 1'b1;
            end
            row.y      = COORD_W'(py) + COORD_W'(r);
            row.x_left = COORD_W'(px) + 1'b1;
            row.fg     = data[83:52];
            row.bg     = data[115:84];
            row.last   = (r == h - 1);
            rows_due.push_back(row);
            ptr = ptr + LOAD_AW'(stride_reg);
        end
    endtask

    task automatic send_beat(input logic kind, input logic [S_TDATA_W-1:0] data);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = kind;
        s_axis_tdata  = data;
        do @(posedge i_clk); while (!s_axis_tready);
        if (kind == KIND_LOAD) begin
            glyph_mem[data[11:0]]   = data[19:12];
            byte_loaded[data[11:0]] = 1'b1;
        end else begin
            predict_glyph_rows(data);
        end
        beats_sent++;
        @(negedge i_clk);
    endtask

    task automatic load_byte(input logic [LOAD_AW-1:0] addr, input logic [BYTE_W-1:0] value);
        send_beat(KIND_LOAD, pack_beat(addr, value, CODE_W'($urandom), POS_W'($urandom),
                                       POS_W'($urandom), $urandom, $urandom));
    endtask

    // loads every byte the glyph will read that has not been written yet
    task automatic render_char(input logic [CODE_W-1:0] code, input logic [POS_W-1:0] px,
                               input logic [POS_W-1:0] py, input logic [PIXEL_W-1:0] fg,
                               input logic [PIXEL_W-1:0] bg);
        logic [LOAD_AW-1:0] ptr;
        logic [LOAD_AW-1:0] addr;
        int                 nbytes;
        ptr    = glyph_base(code);
        nbytes = (eff_width() + 7) / 8;
        for (int r = 0; r < eff_height(); r++) begin
            for (int j = 0; j < nbytes; j++) begin
                addr = ptr + LOAD_AW'(j);
                if (!byte_loaded[addr])
                    load_byte(addr, BYTE_W'($urandom));
            end
            ptr = ptr + LOAD_AW'(stride_reg);
        end
        send_beat(KIND_RENDER, pack_beat(LOAD_AW'($urandom), BYTE_W'($urandom), code,
                                         px, py, fg, bg));
    endtask

    task automatic render_random();
        render_char(CODE_W'($urandom), POS_W'($urandom), POS_W'($urandom),
                    $urandom, $urandom);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] value);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = value;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            CFG_GLYPH_WIDTH:  width_reg  = value[CFG_W_W-1:0];
            CFG_GLYPH_HEIGHT: height_reg = value[CFG_H_W-1:0];
            CFG_GLYPH_BYTES:  bytes_reg  = value[CFG_GB_W-1:0];
            CFG_ROW_STRIDE:   stride_reg = value[CFG_RS_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_glyph_format(input int w, input int h, input int gb, input int rs);
        write_reg(CFG_GLYPH_WIDTH,  {2'($urandom), CFG_W_W'(w)});
        write_reg(CFG_GLYPH_HEIGHT, {2'($urandom), CFG_H_W'(h)});
        write_reg(CFG_GLYPH_BYTES,  CFG_GB_W'(gb));
        write_reg(CFG_ROW_STRIDE,   {5'($urandom), CFG_RS_W'(rs)});
    endtask

    // a zero-height render leaves no row to wait for, so a drain of DRAIN_CYCLES follows the row wait
    task automatic wait_idle();
        s_axis_tvalid = 1'b0;
        while (rows_due.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        $display("mismatch %s: got %h want %h", what, got, want);
    endtask

    always @(negedge i_clk) begin
        if (ready_hold > 0) begin
            m_axis_tready = 1'b0;
            ready_hold--;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            m_axis_tready = 1'b0;
            ready_hold = $urandom_range(1, 15) - 1;
        end else begin
            m_axis_tready = 1'b1;
        end
    end

    // row_y, row_x_left, row_mask, row_fg, row_bg from the lowest bit up
    always @(posedge i_clk) begin : row_check
        t_glyph_row want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (rows_due.size() == 0) begin
                report_mismatch("row beat with none due", 32'(m_axis_tdata[12:0]), 32'h0);
            end else begin
                want = rows_due.pop_front();
                if (m_axis_tdata[12:0] !== want.y)
                    report_mismatch("row_y", 32'(m_axis_tdata[12:0]), 32'(want.y));
                if (m_axis_tdata[25:13] !== want.x_left)
                    report_mismatch("row_x_left", 32'(m_axis_tdata[25:13]), 32'(want.x_left));
                if (m_axis_tdata[57:26] !== want.mask)
                    report_mismatch("row_mask", m_axis_tdata[57:26], want.mask);
                if (m_axis_tdata[89:58] !== want.fg)
                    report_mismatch("row_fg", m_axis_tdata[89:58], want.fg);
                if (m_axis_tdata[121:90] !== want.bg)
                    report_mismatch("row_bg", m_axis_tdata[121:90], want.bg);
                if (m_axis_tlast !== want.last)
                    report_mismatch("last_row", 32'(m_axis_tlast), 32'(want.last));
            end
        end
    end

    task automatic test_reset_defaults();
        load_byte(12'h000, 8'h00);
        load_byte(12'hFFF, 8'hFF);
        render_char(8'h00, 12'h000, 12'h000, 32'h0000_0000, 32'hFFFF_FFFF);
        render_char(8'hFF, 12'hFFF, 12'hFFF, 32'hFFFF_FFFF, 32'h0000_0000);
        wait_idle();
    endtask

    // the tall glyphs sit on code zero so they share bytes already loaded
    task automatic test_register_extremes();
        set_glyph_format(1, 1, 1, 1);
        render_char(8'hFF, 12'hFFF, 12'h000, 32'hA5A5_5A5A, 32'h5A5A_A5A5);
        wait_idle();
        set_glyph_format(32, 32, 128, 4);
        render_char(8'h00, POS_W'($urandom), POS_W'($urandom), $urandom, $urandom);
        wait_idle();
        set_glyph_format(0, 4, 16, 1);
        render_random();
        wait_idle();
        set_glyph_format(63, 63, 255, 7);
        render_char(8'h00, POS_W'($urandom), POS_W'($urandom), $urandom, $urandom);
        wait_idle();
        set_glyph_format(8, 0, 16, 1);
        render_random();
        wait_idle();
        set_glyph_format(16, 4, 0, 0);
        render_random();
        render_random();
        wait_idle();
    endtask

    task automatic test_random_glyphs();
        int w;
        int h;
        int gb;
        int rs;
        while (beats_sent < ITEM_TARGET - TAIL_BEATS) begin
            case ($urandom_range(0, 9))
                0:       w = $urandom_range(33, 63);
                1:       w = 0;
                2:       w = $urandom_range(17, 32);
                default: w = $urandom_range(1, 16);
            endcase
            case ($urandom_range(0, 11))
                0:       h = $urandom_range(33, 63);
                1:       h = 0;
                2:       h = $urandom_range(9, 32);
                default: h = $urandom_range(1, 8);
            endcase
            case ($urandom_range(0, 9))
                0:       gb = 0;
                1:       gb = $urandom_range(129, 255);
                default: gb = $urandom_range(1, 128);
            endcase
            case ($urandom_range(0, 9))
                0:       rs = 0;
                1:       rs = $urandom_range(5, 7);
                default: rs = $urandom_range(1, 4);
            endcase
            set_glyph_format(w, h, gb, rs);
            repeat ($urandom_range(4, 10)) begin
                if (beats_sent < ITEM_TARGET - TAIL_BEATS) begin
                    if ($urandom_range(0, 5) == 0)
                        load_byte(LOAD_AW'($urandom), BYTE_W'($urandom));
                    render_random();
                end
            end
            wait_idle();
        end
    endtask

    task automatic test_unstalled_tail();
        quiet = 1'b1;
        set_glyph_format($urandom_range(1, 16), $urandom_range(1, 4),
                         $urandom_range(1, 128), $urandom_range(1, 4));
        repeat (TAIL_RENDERS) render_random();
        wait_idle();
    endtask

    initial begin
        width_reg  = RST_GLYPH_WIDTH;
        height_reg = RST_GLYPH_HEIGHT;
        bytes_reg  = RST_GLYPH_BYTES;
        stride_reg = RST_ROW_STRIDE;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_reset_defaults();
        test_register_extremes();
        test_random_glyphs();
        test_unstalled_tail();

        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

FILE: files.f
rtl/core/gbr_pkg.sv
rtl/core/gbr_ram.sv
rtl/core/gbr_mirror.sv
rtl/core/bitmap_glyph_row_renderer_core.sv
test/tb_bitmap_glyph_row_renderer_core.sv
